### design/coupled_chaotic_map_byte_generator_top_defines.svh
// Assertion macros for the coupled chaotic map byte generator.
// Used by the top level only; expands to nothing when SYNTH is defined.
`ifndef COUPLED_CHAOTIC_MAP_BYTE_GENERATOR_TOP_DEFINES_SVH
`define COUPLED_CHAOTIC_MAP_BYTE_GENERATOR_TOP_DEFINES_SVH
`ifndef SYNTH
`define CCMBG_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ccmbg assertion failed");
`define CCMBG_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ccmbg assertion failed");
`else
`define CCMBG_ASSERT_IMP(lbl, ante, cons)
`define CCMBG_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

### design/ccmbg_pkg.sv
// Shared constants and types for the coupled chaotic map byte generator.
// No dependencies.
package ccmbg_pkg;

  localparam int CCMBG_SITE_COUNT = 3;
  localparam int CCMBG_FRAC_BITS  = 32;
  localparam int CFG_IDX_W        = 3;

  localparam logic [CFG_IDX_W-1:0] REG_MAP_ALPHA    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BETA_LOW     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BETA_HIGH    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COUPLING     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_SCALE = 3'd4;

  localparam logic [31:0] RST_MAP_ALPHA    = 32'h8000_0000;
  localparam logic [31:0] RST_BETA_LOW     = 32'h4000_0000;
  localparam logic [31:0] RST_BETA_HIGH    = 32'hC000_0000;
  localparam logic [31:0] RST_COUPLING     = 32'd85899346;
  localparam logic [31:0] RST_OUTPUT_SCALE = 32'd1000000;

  typedef struct packed {
    logic load;
    logic shift;
  } cell_ctl_t;

endpackage

### design/ccmbg_mul.sv
// Shift-add multiplier, one operand bit per cycle.
// Depends on nothing; shared by the sequencer in the top level.
module ccmbg_mul #(
  parameter int Width = 33
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [Width-1:0]     op_a,
  input  logic [Width-1:0]     op_b,
  output logic                 busy,
  output logic                 done,
  output logic [2*Width-1:0]   prod
);
  localparam int CntW = $clog2(Width + 1);

  logic [Width-1:0] hi_r, lo_r, a_r;
  logic [CntW-1:0]  cnt_r;
  logic             busy_r, done_r;
  logic [Width:0]   sum_nxt;

  assign sum_nxt = {1'b0, hi_r} + (lo_r[0] ? {1'b0, a_r} : '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CntW'(Width);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CntW'(1);
        if (cnt_r == CntW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r  <= op_a;
      hi_r <= '0;
      lo_r <= op_b;
    end else if (busy_r) begin
      hi_r <= sum_nxt[Width:1];
      lo_r <= {sum_nxt[0], lo_r[Width-1:1]};
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign prod = {hi_r, lo_r};
endmodule

### design/ccmbg_div.sv
// Restoring divider, one quotient bit per cycle, for the map quotient.
// Depends on nothing; driven by the sequencer in the top level.
module ccmbg_div #(
  parameter int FracBits = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [FracBits-1:0] num,
  input  logic [FracBits:0]   den,
  output logic                busy,
  output logic                done,
  output logic [FracBits:0]   quo
);
  localparam int CntW = $clog2(FracBits + 2);

  logic [FracBits+1:0] rem_r, trial, diff;
  logic [FracBits:0]   den_r, q_r;
  logic [CntW-1:0]     cnt_r;
  logic                first_r, busy_r, done_r, ge;

  assign trial = first_r ? rem_r : {rem_r[FracBits:0], 1'b0};
  assign ge    = trial >= {1'b0, den_r};
  assign diff  = trial - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CntW'(FracBits + 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CntW'(1);
        if (cnt_r == CntW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r   <= {2'b00, num};
      den_r   <= den;
      q_r     <= '0;
      first_r <= 1'b1;
    end else if (busy_r) begin
      rem_r   <= ge ? diff : trial;
      q_r     <= {q_r[FracBits-1:0], ge};
      first_r <= 1'b0;
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign quo  = q_r;
endmodule

### design/ccmbg_cell.sv
// One site of the ring: x and y state plus the two map values of a step.
// Depends on ccmbg_pkg for the cell control struct.
module ccmbg_cell #(
  parameter int FracBits = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  ccmbg_pkg::cell_ctl_t  ctl,
  input  logic [FracBits-1:0]   ld_x,
  input  logic [FracBits-1:0]   ld_y,
  input  logic [FracBits-1:0]   in_x,
  input  logic [FracBits-1:0]   in_y,
  input  logic [FracBits:0]     in_px,
  input  logic [FracBits:0]     in_py,
  output logic [FracBits-1:0]   out_x,
  output logic [FracBits-1:0]   out_y,
  output logic [FracBits:0]     out_px,
  output logic [FracBits:0]     out_py
);
  import ccmbg_pkg::*;

  logic [FracBits-1:0] x_r, y_r;
  logic [FracBits:0]   px_r, py_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_r <= '0;
      y_r <= '0;
    end else if (ctl.load) begin
      x_r <= ld_x;
      y_r <= ld_y;
    end else if (ctl.shift) begin
      x_r <= in_x;
      y_r <= in_y;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      px_r <= in_px;
      py_r <= in_py;
    end
  end

  assign out_x  = x_r;
  assign out_y  = y_r;
  assign out_px = px_r;
  assign out_py = py_r;
endmodule

### design/coupled_chaotic_map_byte_generator_top.sv
// Top level of the coupled chaotic map byte generator: config registers,
// sequencer, ring of ccmbg_cell, shared ccmbg_mul and ccmbg_div.
//
// channel  direction  handshake          payload
// in       input      in_valid/in_stall   in_operation, in_seed_x_*, in_seed_y_*
// out      output     out_valid/out_stall out_random_byte, out_trajectory_value
// cfg      input      cfg_valid/cfg_ready cfg_index, cfg_data
//
// A restart loads the seeds into the sites and leaves the sequencer idle. One
// serial multiplier of width MW = max(FRACTION_BITS+1, 32) and one serial divider
// serve the ring head while the ring rotates. The result sits in an output
// register, so a stalled result holds only the next step's final write.
// Reset is synchronous; sites clear to zero, registers take their defaults.
`include "coupled_chaotic_map_byte_generator_top_defines.svh"
module coupled_chaotic_map_byte_generator_top #(
  parameter int SITE_COUNT    = ccmbg_pkg::CCMBG_SITE_COUNT,
  parameter int FRACTION_BITS = ccmbg_pkg::CCMBG_FRAC_BITS
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             in_operation,
  input  logic [31:0]                      in_seed_x_first,
  input  logic [31:0]                      in_seed_x_second,
  input  logic [31:0]                      in_seed_x_third,
  input  logic [31:0]                      in_seed_y_first,
  input  logic [31:0]                      in_seed_y_second,
  input  logic [31:0]                      in_seed_y_third,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [7:0]                       out_random_byte,
  output logic [31:0]                      out_trajectory_value,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [ccmbg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [31:0]                      cfg_data
);
  import ccmbg_pkg::*;

  localparam int F    = FRACTION_BITS;
  localparam int MW   = (F + 1 > 32) ? F + 1 : 32;
  localparam int CntW = $clog2(SITE_COUNT);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_AW   = 4'd1;
  localparam logic [3:0] ST_ASQ  = 4'd2;
  localparam logic [3:0] ST_ATOP = 4'd3;
  localparam logic [3:0] ST_ADIV = 4'd4;
  localparam logic [3:0] ST_BM1  = 4'd5;
  localparam logic [3:0] ST_BM2  = 4'd6;
  localparam logic [3:0] ST_BYTE = 4'd7;
  localparam logic [3:0] ST_OUT  = 4'd8;

  localparam logic [F:0] ONE_F = {1'b1, {F{1'b0}}};

  logic [31:0] alpha_r, beta_lo_r, beta_hi_r, eps_r, scale_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_r   <= RST_MAP_ALPHA;
      beta_lo_r <= RST_BETA_LOW;
      beta_hi_r <= RST_BETA_HIGH;
      eps_r     <= RST_COUPLING;
      scale_r   <= RST_OUTPUT_SCALE;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_MAP_ALPHA:    alpha_r   <= cfg_data;
        REG_BETA_LOW:     beta_lo_r <= cfg_data;
        REG_BETA_HIGH:    beta_hi_r <= cfg_data;
        REG_COUPLING:     eps_r     <= cfg_data;
        REG_OUTPUT_SCALE: scale_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  assign cfg_ready = 1'b1;

  // 32-bit fractions to Q0.F
  logic [F+31:0] alpha_w, blo_w, bhi_w, eps_w;
  logic [F-1:0]  alpha_f, blo_f, bhi_f, eps_f;

  assign alpha_w = {alpha_r, {F{1'b0}}};
  assign blo_w   = {beta_lo_r, {F{1'b0}}};
  assign bhi_w   = {beta_hi_r, {F{1'b0}}};
  assign eps_w   = {eps_r, {F{1'b0}}};
  assign alpha_f = alpha_w[F+31:32];
  assign blo_f   = blo_w[F+31:32];
  assign bhi_f   = bhi_w[F+31:32];
  assign eps_f   = eps_w[F+31:32];

  logic [3:0]      state_r;
  logic            go_r, sel_y_r;
  logic [CntW-1:0] cnt_r;
  logic [F:0]      w_r, phx_r;
  logic [F-1:0]    sq_r, top_r, nx_r;
  logic [2*MW-1:0] acc_r;
  logic            out_valid_r;
  logic [7:0]      byte_r;
  logic [31:0]     traj_r;

  logic [F-1:0] cx [SITE_COUNT];
  logic [F-1:0] cy [SITE_COUNT];
  logic [F:0]   cpx [SITE_COUNT];
  logic [F:0]   cpy [SITE_COUNT];
  logic [F-1:0] hx, hy;
  logic [F:0]   hpx, hpy;
  cell_ctl_t    cell_ctl;

  logic [31:0] seed_x [3];
  logic [31:0] seed_y [3];

  assign seed_x[0] = in_seed_x_first;
  assign seed_x[1] = in_seed_x_second;
  assign seed_x[2] = in_seed_x_third;
  assign seed_y[0] = in_seed_y_first;
  assign seed_y[1] = in_seed_y_second;
  assign seed_y[2] = in_seed_y_third;

  logic            mul_start, mul_busy, mul_done;
  logic [MW-1:0]   mul_a, mul_b;
  logic [2*MW-1:0] mul_prod;
  logic            div_start, div_busy, div_done;
  logic [F:0]      div_quo, den_c, phi_c;
  logic [F+1:0]    den_sum;
  logic [F-1:0]    head_v, head_p, mix_val;
  logic [2*MW-1:0] mix_sum;
  logic            last_site, shift_c, load_c;
  logic [F+31:0]   traj_w;

  assign head_v  = sel_y_r ? cy[0] : cx[0];
  assign head_p  = sel_y_r ? (cx[0][F-1] ? bhi_f : blo_f) : alpha_f;
  assign den_sum = {1'b0, top_r} + ({1'b0, ONE_F} - {1'b0, w_r});
  assign den_c   = den_sum[F:0];
  assign phi_c   = (den_c == '0) ? '0 : div_quo;
  assign mix_sum = acc_r + mul_prod;
  assign mix_val = mix_sum[2*F-1:F];
  assign traj_w  = {cy[0], 32'd0};

  assign last_site = (cnt_r == CntW'(SITE_COUNT - 1));
  assign shift_c   = sel_y_r && ((state_r == ST_ADIV && div_done)
                              || (state_r == ST_BM2 && mul_done));
  assign load_c    = (state_r == ST_IDLE) && in_valid && in_operation;
  assign cell_ctl  = '{load: load_c, shift: shift_c};

  always_comb begin
    if (state_r == ST_ADIV) begin
      hx  = cx[0];
      hy  = cy[0];
      hpx = phx_r;
      hpy = phi_c;
    end else begin
      hx  = nx_r;
      hy  = mix_val;
      hpx = cpx[0];
      hpy = cpy[0];
    end
  end

  always_comb begin
    case (state_r)
      ST_AW: begin
        mul_a = MW'(head_v);
        mul_b = MW'(ONE_F - {1'b0, head_v});
      end
      ST_ASQ: begin
        mul_a = MW'(head_p);
        mul_b = MW'(head_p);
      end
      ST_ATOP: begin
        mul_a = MW'(sq_r);
        mul_b = MW'(w_r);
      end
      ST_BM1: begin
        mul_a = MW'(ONE_F - {1'b0, eps_f});
        mul_b = MW'(sel_y_r ? cpy[0] : cpx[0]);
      end
      ST_BM2: begin
        mul_a = MW'(eps_f);
        mul_b = MW'(sel_y_r ? cpy[1] : cpx[1]);
      end
      ST_BYTE: begin
        mul_a = MW'(cy[0]);
        mul_b = MW'(scale_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_start = go_r && (state_r == ST_AW || state_r == ST_ASQ || state_r == ST_ATOP
                           || state_r == ST_BM1 || state_r == ST_BM2 || state_r == ST_BYTE);
  assign div_start = go_r && (state_r == ST_ADIV);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      go_r        <= 1'b0;
      sel_y_r     <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      go_r <= 1'b0;
      if (out_valid_r && !out_stall && state_r != ST_OUT) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_valid && !in_operation) begin
            state_r <= ST_AW;
            go_r    <= 1'b1;
            sel_y_r <= 1'b0;
            cnt_r   <= '0;
          end
        end
        ST_AW: begin
          if (mul_done) begin
            state_r <= ST_ASQ;
            go_r    <= 1'b1;
          end
        end
        ST_ASQ: begin
          if (mul_done) begin
            state_r <= ST_ATOP;
            go_r    <= 1'b1;
          end
        end
        ST_ATOP: begin
          if (mul_done) begin
            state_r <= ST_ADIV;
            go_r    <= 1'b1;
          end
        end
        ST_ADIV: begin
          if (div_done) begin
            go_r <= 1'b1;
            if (!sel_y_r) begin
              sel_y_r <= 1'b1;
              state_r <= ST_AW;
            end else begin
              sel_y_r <= 1'b0;
              if (last_site) begin
                cnt_r   <= '0;
                state_r <= ST_BM1;
              end else begin
                cnt_r   <= cnt_r + CntW'(1);
                state_r <= ST_AW;
              end
            end
          end
        end
        ST_BM1: begin
          if (mul_done) begin
            state_r <= ST_BM2;
            go_r    <= 1'b1;
          end
        end
        ST_BM2: begin
          if (mul_done) begin
            go_r <= 1'b1;
            if (!sel_y_r) begin
              sel_y_r <= 1'b1;
              state_r <= ST_BM1;
            end else begin
              sel_y_r <= 1'b0;
              if (last_site) begin
                cnt_r   <= '0;
                state_r <= ST_BYTE;
              end else begin
                cnt_r   <= cnt_r + CntW'(1);
                state_r <= ST_BM1;
              end
            end
          end
        end
        ST_BYTE: begin
          if (mul_done) begin
            state_r <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r <= 1'b1;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_AW && mul_done) begin
      w_r <= mul_prod[2*F-2:F-2];
    end
    if (state_r == ST_ASQ && mul_done) begin
      sq_r <= mul_prod[2*F-1:F];
    end
    if (state_r == ST_ATOP && mul_done) begin
      top_r <= mul_prod[2*F-1:F];
    end
    if (state_r == ST_ADIV && div_done && !sel_y_r) begin
      phx_r <= phi_c;
    end
    if (state_r == ST_BM1 && mul_done) begin
      acc_r <= mul_prod;
    end
    if (state_r == ST_BM2 && mul_done && !sel_y_r) begin
      nx_r <= mix_val;
    end
    if (state_r == ST_OUT && (!out_valid_r || !out_stall)) begin
      byte_r <= mul_prod[F+7:F];
      traj_r <= traj_w[F+31:F];
    end
  end

  genvar gi;
  generate
    for (gi = 0; gi < SITE_COUNT; gi++) begin : g_site
      logic [F-1:0]  ld_x, ld_y, nb_x, nb_y;
      logic [F:0]    nb_px, nb_py;
      logic [F+31:0] sx_w, sy_w;

      if (gi < 3) begin : g_seed
        assign sx_w = {seed_x[gi], {F{1'b0}}};
        assign sy_w = {seed_y[gi], {F{1'b0}}};
      end else begin : g_noseed
        assign sx_w = '0;
        assign sy_w = '0;
      end
      assign ld_x = sx_w[F+31:32];
      assign ld_y = sy_w[F+31:32];

      if (gi == SITE_COUNT - 1) begin : g_tail
        assign nb_x  = hx;
        assign nb_y  = hy;
        assign nb_px = hpx;
        assign nb_py = hpy;
      end else begin : g_mid
        assign nb_x  = cx[gi+1];
        assign nb_y  = cy[gi+1];
        assign nb_px = cpx[gi+1];
        assign nb_py = cpy[gi+1];
      end

      ccmbg_cell #(.FracBits(F)) u_cell (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (cell_ctl),
        .ld_x   (ld_x),
        .ld_y   (ld_y),
        .in_x   (nb_x),
        .in_y   (nb_y),
        .in_px  (nb_px),
        .in_py  (nb_py),
        .out_x  (cx[gi]),
        .out_y  (cy[gi]),
        .out_px (cpx[gi]),
        .out_py (cpy[gi])
      );
    end
  endgenerate

  ccmbg_mul #(.Width(MW)) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .op_a  (mul_a),
    .op_b  (mul_b),
    .busy  (mul_busy),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  ccmbg_div #(.FracBits(F)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (top_r),
    .den   (den_c),
    .busy  (div_busy),
    .done  (div_done),
    .quo   (div_quo)
  );

  assign in_stall             = (state_r != ST_IDLE);
  assign out_valid            = out_valid_r;
  assign out_random_byte      = byte_r;
  assign out_trajectory_value = traj_r;

  `CCMBG_ASSERT_NXT(a_restart_stays_idle, in_valid && !in_stall && in_operation, state_r == ST_IDLE)
  `CCMBG_ASSERT_NXT(a_step_starts, in_valid && !in_stall && !in_operation, state_r == ST_AW && cnt_r == '0 && !sel_y_r)
  `CCMBG_ASSERT_IMP(a_units_exclusive, mul_busy, !div_busy)
  `CCMBG_ASSERT_NXT(a_result_from_out, state_r != ST_OUT && !out_valid_r, !out_valid_r)
endmodule

### bench/tb.sv
// Self-checking bench for coupled_chaotic_map_byte_generator_top: seeds and steps
// the ring and checks every emitted byte and trajectory value against an in-bench model.
// Depends on ccmbg_pkg and the top level only.
`timescale 1ns / 100ps
module tb;
  import ccmbg_pkg::*;

  typedef logic [31:0] seed_set_t [6];
  typedef struct {
    logic [7:0]  rnd_byte;
    logic [31:0] traj;
  } draw_t;

  localparam logic OP_STEP    = 1'b0;
  localparam logic OP_RESTART = 1'b1;
  localparam int   STEP_CYCLES = 1300;
  localparam longint CYCLE_LIMIT = 64'd20_000_000;

  logic clk, rst_n;
  logic in_valid, in_stall, in_operation;
  logic [31:0] in_seed_x_first, in_seed_x_second, in_seed_x_third;
  logic [31:0] in_seed_y_first, in_seed_y_second, in_seed_y_third;
  logic out_valid, out_stall;
  logic [7:0] out_random_byte;
  logic [31:0] out_trajectory_value;
  logic cfg_valid, cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [31:0] cfg_data;

  logic [31:0] alpha_q, beta_lo_q, beta_hi_q, eps_q, scale_q;
  logic [31:0] ring_x [3];
  logic [31:0] ring_y [3];
  draw_t pending_draws[$];
  int mismatches;
  longint cycles;
  bit calm;

  coupled_chaotic_map_byte_generator_top i_dut (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic logic [32:0] chaos_map(logic [31:0] v, logic [31:0] a);
    logic [63:0] prod;
    logic [32:0] w, top, den;
    logic [31:0] sq;
    logic [127:0] q;
    prod = 64'(v) * (64'h1_0000_0000 - 64'(v));
    w = 33'(prod >> 30);
    sq = 32'((64'(a) * 64'(a)) >> 32);
    top = 33'((64'(sq) * 64'(w)) >> 32);
    den = top + (33'h1_0000_0000 - w);
    if (den == 0) return 33'd0;
    q = (128'(top) << 32) / 128'(den);
    return q[32:0];
  endfunction

  function automatic logic [31:0] blend(logic [32:0] self_v, logic [32:0] nb_v,
                                        logic [31:0] eps);
    logic [127:0] s;
    s = 128'(65'h1_0000_0000 - 65'(eps)) * 128'(self_v) + 128'(eps) * 128'(nb_v);
    return s[63:32];
  endfunction

  function automatic logic [31:0] beta_of(logic [31:0] x);
    return (x < 32'h8000_0000) ? beta_lo_q : beta_hi_q;
  endfunction

  task automatic advance_ring();
    logic [31:0] nx [3];
    logic [31:0] ny [3];
    logic [63:0] scaled;
    int n;
    draw_t d;
    for (int i = 0; i < 3; i++) begin
      n = (i + 1) % 3;
      nx[i] = blend(chaos_map(ring_x[i], alpha_q), chaos_map(ring_x[n], alpha_q), eps_q);
      ny[i] = blend(chaos_map(ring_y[i], beta_of(ring_x[i])),
                    chaos_map(ring_y[n], beta_of(ring_x[n])), eps_q);
    end
    ring_x = nx;
    ring_y = ny;
    scaled = 64'(ring_y[0]) * 64'(scale_q);
    d.rnd_byte = scaled[39:32];
    d.traj = ring_y[0];
    pending_draws = {pending_draws, d};
  endtask

  task automatic send_item(logic op, seed_set_t s);
    if (!calm && $urandom_range(99) < 26) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat ($urandom_range(5)) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_operation <= op;
    in_seed_x_first <= s[0];
    in_seed_x_second <= s[1];
    in_seed_x_third <= s[2];
    in_seed_y_first <= s[3];
    in_seed_y_second <= s[4];
    in_seed_y_third <= s[5];
    do @(posedge clk); while (!(in_valid && !in_stall));
    if (op == OP_RESTART) begin
      for (int i = 0; i < 3; i++) begin
        ring_x[i] = s[i];
        ring_y[i] = s[3 + i];
      end
    end else begin
      advance_ring();
    end
  endtask

  task automatic restart(seed_set_t s);
    send_item(OP_RESTART, s);
  endtask

  task automatic step(int count);
    seed_set_t s;
    for (int k = 0; k < 6; k++) s[k] = $urandom;
    repeat (count) send_item(OP_STEP, s);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_draws.size() != 0) @(posedge clk);
    repeat (STEP_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_MAP_ALPHA:    alpha_q = data;
      REG_BETA_LOW:     beta_lo_q = data;
      REG_BETA_HIGH:    beta_hi_q = data;
      REG_COUPLING:     eps_q = data;
      REG_OUTPUT_SCALE: scale_q = data;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic cfg_all(logic [31:0] a, logic [31:0] bl, logic [31:0] bh,
                         logic [31:0] e, logic [31:0] p);
    cfg_write(REG_MAP_ALPHA, a);
    cfg_write(REG_BETA_LOW, bl);
    cfg_write(REG_BETA_HIGH, bh);
    cfg_write(REG_COUPLING, e);
    cfg_write(REG_OUTPUT_SCALE, p);
  endtask

  function automatic logic [31:0] pick_seed();
    case ($urandom_range(9))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      2: return 32'h8000_0000;
      3: return 32'h7FFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic seed_set_t random_seeds();
    seed_set_t s;
    for (int k = 0; k < 6; k++) s[k] = pick_seed();
    return s;
  endfunction

  always @(negedge clk) begin
    if (!rst_n) out_stall <= 1'b0;
    else out_stall <= !calm && ($urandom_range(99) < 26);
  end

  always @(posedge clk) begin
    draw_t d;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_draws.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected transfer: byte %0d traj %h",
                                       out_random_byte, out_trajectory_value);
      end else begin
        d = pending_draws.pop_front();
        if (out_random_byte !== d.rnd_byte || out_trajectory_value !== d.traj) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: byte exp %0d got %0d, traj exp %h got %h",
                     d.rnd_byte, out_random_byte, d.traj, out_trajectory_value);
        end
      end
    end
  end

  task automatic test_defaults();
    restart('{32'h1234_5678, 32'h9ABC_DEF0, 32'h0F0F_0F0F,
              32'h3333_3333, 32'hCCCC_CCCC, 32'h5555_5555});
    step(4);
    restart('{32'h0, 32'hFFFF_FFFF, 32'h8000_0000,
              32'hFFFF_FFFF, 32'h0, 32'h8000_0000});
    step(3);
    restart('{32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
              32'h8000_0000, 32'h8000_0000, 32'h8000_0000});
    step(2);
    drain();
  endtask

  task automatic test_config_extremes();
    cfg_all(32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
    cfg_write(3'd5, 32'hDEAD_BEEF);
    cfg_write(3'd7, 32'h0);
    restart('{32'h8000_0000, 32'h8000_0000, 32'h4000_0000,
              32'h8000_0000, 32'h8000_0000, 32'h8000_0000});
    step(2);
    drain();
    cfg_all(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    restart('{32'h2000_0000, 32'h8000_0000, 32'hE000_0000,
              32'h8000_0000, 32'h1000_0000, 32'hFFFF_FFFF});
    step(3);
    drain();
    cfg_all(32'hFFFF_FFFF, 32'h1, 32'hFFFF_FFFE, 32'h1, 32'h1);
    restart(random_seeds());
    step(3);
    drain();
  endtask

  task automatic test_random();
    int sent;
    sent = 0;
    for (int phase = 0; phase < 8; phase++) begin
      cfg_all($urandom, $urandom, $urandom, $urandom_range(2) == 0 ? $urandom : $urandom_range(1 << 28),
              $urandom_range(1) ? $urandom : $urandom_range(1, 2000000));
      calm = (phase == 3);
      while (sent < (phase + 1) * 200) begin
        restart(random_seeds());
        sent++;
        for (int k = $urandom_range(1, 12); k > 0; k--) begin
          step(1);
          sent++;
        end
        if (phase == 5 && sent % 100 < 10) drain();
      end
      calm = 1'b0;
      drain();
    end
  endtask

  initial begin
    mismatches = 0;
    cycles = 0;
    calm = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_operation = OP_STEP;
    in_seed_x_first = '0;
    in_seed_x_second = '0;
    in_seed_x_third = '0;
    in_seed_y_first = '0;
    in_seed_y_second = '0;
    in_seed_y_third = '0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    alpha_q = RST_MAP_ALPHA;
    beta_lo_q = RST_BETA_LOW;
    beta_hi_q = RST_BETA_HIGH;
    eps_q = RST_COUPLING;
    scale_q = RST_OUTPUT_SCALE;
    for (int i = 0; i < 3; i++) begin
      ring_x[i] = '0;
      ring_y[i] = '0;
    end
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    step(2);
    test_defaults();
    test_config_extremes();
    test_random();
    drain();
    if (mismatches == 0 && pending_draws.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
